/* hdl/bdre_pkg.sv */
`default_nettype none
package bdre_pkg;

  localparam int unsigned OffsetW = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = 2;
  localparam int unsigned OutCntW  = 3;
  localparam logic [ByteW-1:0] MaxRunReset = 8'd255;

  // One result item as it travels through the output queue.
  typedef struct packed {
    logic [OffsetW-1:0] run_offset;
    logic [ByteW-1:0]   data_byte;
    logic [ByteW-1:0]   index_in_run;
    logic               last_in_run;
    logic [ByteW-1:0]   run_length;
  } result_t;

  // Which of the two result slots the step logic fills in one cycle.
  // The second slot is only ever used together with the first one.
  typedef struct packed {
    logic first_valid;
    logic second_valid;
  } push_t;

endpackage
`default_nettype wire

/* hdl/bdre_step.sv */
`default_nettype none
module bdre_step #(
  parameter int unsigned CHUNK_BYTES = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [bdre_pkg::ByteW-1:0] cfg_data_i,
  input  wire logic                      accept_i,
  input  wire logic [bdre_pkg::ByteW-1:0] orig_byte_i,
  input  wire logic [bdre_pkg::ByteW-1:0] patched_byte_i,
  input  wire logic                      end_of_data_i,
  output bdre_pkg::push_t                push_o,
  output bdre_pkg::result_t              first_o,
  output bdre_pkg::result_t              second_o
);

  localparam int unsigned ChunkW = $clog2(CHUNK_BYTES);
  localparam logic [ChunkW-1:0] ChunkLast = ChunkW'(CHUNK_BYTES - 1);

  logic [bdre_pkg::OffsetW-1:0] byte_offset_q, byte_offset_d;
  logic [bdre_pkg::OffsetW-1:0] run_start_q, run_start_d;
  logic [ChunkW-1:0]            chunk_pos_q, chunk_pos_d;
  logic [bdre_pkg::ByteW-1:0]   run_count_q, run_count_d;
  logic                         held_valid_q, held_valid_d;
  logic [bdre_pkg::ByteW-1:0]   held_byte_q, held_byte_d;
  logic [bdre_pkg::ByteW-1:0]   max_run_q;

  logic diff, boundary, extend;
  bdre_pkg::result_t held_res, tail_res;

  // The chunk position tracks byte_offset modulo the chunk size; it restarts
  // when the offset wraps, so offset zero is always a boundary.
  assign diff     = orig_byte_i != patched_byte_i;
  assign boundary = (chunk_pos_q == '0) || (byte_offset_q == '0);
  assign extend   = held_valid_q && diff && !boundary && (run_count_q < max_run_q);

  always_comb begin
    held_res.run_offset   = run_start_q;
    held_res.data_byte    = held_byte_q;
    held_res.index_in_run = run_count_q - 8'd1;
    held_res.last_in_run  = !extend;
    held_res.run_length   = extend ? '0 : run_count_q;

    run_start_d  = run_start_q;
    run_count_d  = '0;
    held_valid_d = 1'b0;
    held_byte_d  = held_byte_q;
    if (diff) begin
      held_valid_d = 1'b1;
      held_byte_d  = patched_byte_i;
      if (extend) begin
        run_count_d = run_count_q + 8'd1;
      end else begin
        run_start_d = byte_offset_q;
        run_count_d = 8'd1;
      end
    end

    // A differing final byte closes its own run right away.
    tail_res.run_offset   = run_start_d;
    tail_res.data_byte    = patched_byte_i;
    tail_res.index_in_run = run_count_d - 8'd1;
    tail_res.last_in_run  = 1'b1;
    tail_res.run_length   = run_count_d;

    byte_offset_d = byte_offset_q + 32'd1;
    if (byte_offset_q == '1 || chunk_pos_q == ChunkLast) begin
      chunk_pos_d = '0;
    end else begin
      chunk_pos_d = chunk_pos_q + ChunkW'(1);
    end

    if (end_of_data_i) begin
      byte_offset_d = '0;
      chunk_pos_d   = '0;
      run_start_d   = '0;
      run_count_d   = '0;
      held_valid_d  = 1'b0;
      held_byte_d   = '0;
    end
  end

  always_comb begin
    push_o.first_valid  = accept_i && (held_valid_q || (end_of_data_i && diff));
    push_o.second_valid = accept_i && held_valid_q && end_of_data_i && diff;
    first_o  = held_valid_q ? held_res : tail_res;
    second_o = tail_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q <= '0;
      run_start_q   <= '0;
      chunk_pos_q   <= '0;
      run_count_q   <= '0;
      held_valid_q  <= 1'b0;
      held_byte_q   <= '0;
      max_run_q     <= bdre_pkg::MaxRunReset;
    end else begin
      if (cfg_we_i) begin
        max_run_q <= cfg_data_i;
      end
      if (accept_i) begin
        byte_offset_q <= byte_offset_d;
        run_start_q   <= run_start_d;
        chunk_pos_q   <= chunk_pos_d;
        run_count_q   <= run_count_d;
        held_valid_q  <= held_valid_d;
        held_byte_q   <= held_byte_d;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/bdre_out_queue.sv */
`default_nettype none
module bdre_out_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire bdre_pkg::push_t  push_i,
  input  wire bdre_pkg::result_t first_i,
  input  wire bdre_pkg::result_t second_i,
  output logic             room_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output bdre_pkg::result_t head_o
);

  bdre_pkg::result_t mem_q [bdre_pkg::OutDepth];
  logic [bdre_pkg::OutPtrW-1:0] wptr_q, rptr_q;
  logic [bdre_pkg::OutCntW-1:0] count_q, count_d;
  logic [bdre_pkg::OutCntW-1:0] push_n;
  logic pop;

  assign push_n  = bdre_pkg::OutCntW'(push_i.first_valid) +
                   bdre_pkg::OutCntW'(push_i.second_valid);
  assign valid_o = count_q != '0;
  assign pop     = valid_o && ready_i;
  assign head_o  = mem_q[rptr_q];
  // Room for the two results that the worst-case item can produce.
  assign room_o  = count_q <= bdre_pkg::OutCntW'(bdre_pkg::OutDepth - 2);
  assign count_d = count_q + push_n - bdre_pkg::OutCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.first_valid) begin
      mem_q[wptr_q] <= first_i;
    end
    if (push_i.second_valid) begin
      mem_q[wptr_q + bdre_pkg::OutPtrW'(1)] <= second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + bdre_pkg::OutPtrW'(push_n);
      rptr_q  <= rptr_q + bdre_pkg::OutPtrW'(pop);
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != '0) |-> ({1'b0, count_q} + {1'b0, push_n} <= 4'(bdre_pkg::OutDepth)))
    else $error("output queue overflow");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.second_valid |-> push_i.first_valid)
    else $error("second result pushed without first");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (count_q == $past(count_d)))
    else $error("queue count lost track");

  a_ptr_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != 3'd4) |-> (bdre_pkg::OutPtrW'(wptr_q - rptr_q) == count_q[1:0]))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

/* hdl/byte_diff_run_encoder_core.sv */
`default_nettype none
// Byte difference run encoder.
// The slave stream takes one request per byte pair: tdata carries the
// original byte (low) and the patched byte (high), tlast marks the final
// pair of the files. The master stream gives one request per differing
// patched byte, with its run start offset, its index inside the run, and
// tlast set on the byte that closes the run, together with the run length.
// Runs close at a matching byte, at max_run_length bytes, at a chunk
// boundary every CHUNK_BYTES bytes and at end of data.
// Throughput: one byte pair per cycle while s_axis_tready_o is high.
// A differing byte is held until the next pair shows whether the run goes
// on, so its result is queued when that next pair is accepted; a final
// pair is queued as it is accepted and can yield two results.
// Results wait in a four-entry queue; s_axis_tready_o is low while fewer
// than two entries are free, so a stalled receiver stops input before the
// queue can overflow, and nothing is lost. Reset empties the queue, restarts
// the offset at zero and sets max_run_length to 255. The configuration channel
// is always ready and should only be written while the block is idle.
module byte_diff_run_encoder_core #(
  parameter int unsigned CHUNK_BYTES = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,     // max_run_length
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i, // orig_byte[7:0], patched_byte[15:8]
  input  wire logic        s_axis_tlast_i, // end_of_data
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // run_offset[31:0], data_byte[39:32], index_in_run[47:40], run_length[55:48]
  output logic [55:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o  // last_in_run
);

  bdre_pkg::push_t   push;
  bdre_pkg::result_t first_res, second_res, head;
  logic accept, room;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i && room;

  bdre_step #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .orig_byte_i    (s_axis_tdata_i[7:0]),
    .patched_byte_i (s_axis_tdata_i[15:8]),
    .end_of_data_i  (s_axis_tlast_i),
    .push_o         (push),
    .first_o        (first_res),
    .second_o       (second_res)
  );

  bdre_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (first_res),
    .second_i (second_res),
    .room_o   (room),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .head_o   (head)
  );

  assign m_axis_tdata_o = {head.run_length, head.index_in_run, head.data_byte,
                           head.run_offset};
  assign m_axis_tlast_o = head.last_in_run;

endmodule
`default_nettype wire
